// ===== rtl/core/sbs_pkg.sv =====
// Shared types and constants for the SR-IOV VF BAR sizer.
// Used by sbs_front, sbs_queue, sbs_back and sriov_vf_bar_sizer; no dependencies.
package sbs_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_SRIOV_PRESENT = 3'd0;
  localparam logic [2:0] CFG_VF_COUNT      = 3'd1;
  localparam logic [2:0] CFG_PAGE_SIZE     = 3'd2;
  localparam logic [2:0] CFG_MEM64_OK      = 3'd3;
  localparam logic [2:0] CFG_PMEM64_OK     = 3'd4;

  localparam logic [31:0] PAGE_SIZE_RST = 32'd4096;

  // result status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_ABSENT       = 3'd1;
  localparam logic [2:0] ST_IO           = 3'd2;
  localparam logic [2:0] ST_UPPER_ABSENT = 3'd3;
  localparam logic [2:0] ST_NO_CAP       = 3'd4;

  // BAR kinds
  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_MEM32   = 3'd1;
  localparam logic [2:0] KIND_PMEM32  = 3'd2;
  localparam logic [2:0] KIND_MEM64   = 3'd3;
  localparam logic [2:0] KIND_PMEM64  = 3'd4;

  // BAR dword flag bits
  localparam logic [31:0] FLAG_MASK = 32'hffff_fff0;
  localparam logic [2:0]  TY_MEM32  = 3'h0;
  localparam logic [2:0]  TY_MEM64  = 3'h4;

  typedef struct packed {
    logic        sriov_present;
    logic [15:0] vf_count;
    logic [31:0] page_size;
    logic        mem64_ok;
    logic        pmem64_ok;
  } sbs_cfg_t;

  // decoded item handed from front to back; len is per-VF, mult is its factor
  typedef struct packed {
    logic [2:0]  slot;
    logic [11:0] roff;
    logic [12:0] noff;
    logic [2:0]  status;
    logic [2:0]  kind;
    logic [63:0] base;
    logic [63:0] len;
    logic [15:0] mult;
    logic [63:0] align;
  } sbs_op_t;

endpackage

// ===== rtl/core/sbs_front.sv =====
// Front end of the BAR sizer: accepts BAR dwords, holds the low half of
// 64-bit BARs and decodes each item into an sbs_op_t. Depends on sbs_pkg.
module sbs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  sbs_pkg::sbs_cfg_t   cfg,
  input  logic                acc,
  input  logic [2:0]          bar_index,
  input  logic [11:0]         bar_offset,
  input  logic                probe_ok,
  input  logic [31:0]         sized_value,
  input  logic [31:0]         original_value,
  output logic                push,
  output sbs_pkg::sbs_op_t    op
);

  logic        upper_pending_r;
  logic [31:0] held_base_low_r;
  logic [31:0] held_length_low_r;
  logic [2:0]  held_kind_r;
  logic [2:0]  held_slot_r;
  logic [11:0] held_offset_r;

  logic [31:0] smear, fill_v, sz, floor_v;
  logic [63:0] raw64, am1_64, am1_32, am1;
  logic [2:0]  ty;
  logic        pref, is_io, hold;
  logic [2:0]  hold_kind;

  always_comb begin
    // bits at and above the top set bit of the upper dword become ones
    smear = sized_value;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    fill_v = sized_value | ~(smear >> 1);

    raw64  = {fill_v, held_length_low_r};
    am1_64 = ~raw64;                      // (-raw) - 1
    sz     = sized_value & sbs_pkg::FLAG_MASK;
    am1_32 = (sz == 32'd0) ? {64{1'b1}} : {32'd0, ~sz};
    am1    = upper_pending_r ? am1_64 : am1_32;
    floor_v = cfg.page_size - 32'd1;

    ty    = sized_value[2:0];
    pref  = sized_value[3];
    is_io = sized_value[0];
    hold_kind = pref ? (cfg.pmem64_ok ? sbs_pkg::KIND_PMEM64 : sbs_pkg::KIND_PMEM32)
                     : (cfg.mem64_ok  ? sbs_pkg::KIND_MEM64  : sbs_pkg::KIND_MEM32);
    hold = cfg.sriov_present && !upper_pending_r && probe_ok && !is_io &&
           (ty == sbs_pkg::TY_MEM64);

    op = '0;
    op.mult = 16'd1;
    if (!cfg.sriov_present) begin
      op.slot   = bar_index;
      op.roff   = bar_offset;
      op.status = sbs_pkg::ST_NO_CAP;
    end else if (upper_pending_r) begin
      op.slot = held_slot_r;
      op.roff = held_offset_r;
      op.noff = {1'b0, held_offset_r} + 13'd8;
      if (!probe_ok) begin
        op.status = sbs_pkg::ST_UPPER_ABSENT;
      end else begin
        op.status = sbs_pkg::ST_OK;
        op.kind   = held_kind_r;
        op.base   = {original_value, held_base_low_r};
        op.len    = am1_64 + 64'd1;
        op.mult   = cfg.vf_count;
        op.align  = (am1 < {32'd0, floor_v}) ? {32'd0, floor_v} : am1;
      end
    end else if (!probe_ok || is_io) begin
      op.slot   = bar_index;
      op.roff   = bar_offset;
      op.noff   = {1'b0, bar_offset} + 13'd4;
      op.status = probe_ok ? sbs_pkg::ST_IO : sbs_pkg::ST_ABSENT;
    end else begin
      op.slot   = bar_index;
      op.roff   = bar_offset;
      op.noff   = {1'b0, bar_offset} + 13'd4;
      op.status = sbs_pkg::ST_OK;
      op.base   = {32'd0, original_value & sbs_pkg::FLAG_MASK};
      op.len    = {32'd0, ~sz + 32'd1};
      op.align  = (am1 < {32'd0, floor_v}) ? {32'd0, floor_v} : am1;
      if (ty == sbs_pkg::TY_MEM32) begin
        op.kind = pref ? sbs_pkg::KIND_PMEM32 : sbs_pkg::KIND_MEM32;
        op.mult = cfg.vf_count;
      end else begin
        op.kind = sbs_pkg::KIND_UNKNOWN;   // reserved type: no VF scaling
      end
    end
    push = acc && !hold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_pending_r   <= 1'b0;
      held_base_low_r   <= '0;
      held_length_low_r <= '0;
      held_kind_r       <= '0;
      held_slot_r       <= '0;
      held_offset_r     <= '0;
    end else if (acc) begin
      upper_pending_r <= hold;
      if (hold) begin
        held_base_low_r   <= original_value & sbs_pkg::FLAG_MASK;
        held_length_low_r <= sz;
        held_kind_r       <= hold_kind;
        held_slot_r       <= bar_index;
        held_offset_r     <= bar_offset;
      end
    end
  end

endmodule

// ===== rtl/core/sbs_queue.sv =====
// Short FIFO of decoded items between the sizer front and back.
// Depends on sbs_pkg for the item type.
module sbs_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sbs_pkg::sbs_op_t wr_op,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output sbs_pkg::sbs_op_t rd_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbs_pkg::sbs_op_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_op    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CNT_W'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue read while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not follow a lone write");

endmodule

// ===== rtl/core/sbs_back.sv =====
// Back end of the BAR sizer: scales the per-VF length by the VF count in two
// stages and drives the output register. Depends on sbs_pkg.
module sbs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  sbs_pkg::sbs_op_t q_op,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       slot,
  output logic [11:0]      record_offset,
  output logic [12:0]      next_offset,
  output logic [2:0]       status,
  output logic [2:0]       bar_kind,
  output logic [63:0]      base_address,
  output logic [63:0]      total_length,
  output logic [63:0]      align_mask
);

  logic             s1_valid_r, out_valid_r;
  sbs_pkg::sbs_op_t s1_op_r;
  logic [47:0]      p_lo_r;
  logic [31:0]      p_hi_r;
  logic             s1_ready, s2_ready;
  logic [63:0]      total_nxt;
  logic             zero_len;

  assign s2_ready  = !out_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign pop       = q_valid && s1_ready;
  assign out_valid = out_valid_r;

  // only the low 32 bits of the upper partial product land below bit 64
  assign total_nxt = {p_hi_r, 32'd0} + {16'd0, p_lo_r};
  assign zero_len  = (total_nxt == 64'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= q_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_op_r <= q_op;
      p_lo_r  <= {16'd0, q_op.len[31:0]} * {32'd0, q_op.mult};
      p_hi_r  <= q_op.len[63:32] * {16'd0, q_op.mult};
    end
    if (s2_ready) begin
      slot          <= s1_op_r.slot;
      record_offset <= s1_op_r.roff;
      next_offset   <= s1_op_r.noff;
      status        <= s1_op_r.status;
      total_length  <= total_nxt;
      bar_kind      <= zero_len ? sbs_pkg::KIND_UNKNOWN : s1_op_r.kind;
      base_address  <= zero_len ? 64'd0 : s1_op_r.base;
      align_mask    <= zero_len ? 64'd0 : s1_op_r.align;
    end
  end

  a_zero_len_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && total_length == 64'd0) |->
      (base_address == 64'd0 && align_mask == 64'd0 &&
       bar_kind == sbs_pkg::KIND_UNKNOWN))
    else $error("zero-length record carries base, kind or alignment");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("output item appeared without a multiply stage item");

endmodule

// ===== rtl/core/sriov_vf_bar_sizer.sv =====
// SR-IOV VF BAR sizer top level: config registers, front decoder, item queue
// and multiply back end. Depends on sbs_pkg, sbs_front, sbs_queue, sbs_back.
// An item is queued when the edge accepts its last dword, then passes the multiply
// stage and output registers. Throughput: one dword per cycle; the lower dword of a 64-bit
// BAR gives no item. in_tready falls only when the QUEUE_DEPTH-entry queue fills.
// Reset (rst_n, synchronous, active low) clears control state; config returns to defaults.
module sriov_vf_bar_sizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  // configuration write port
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] bar_index, [14:3] bar_offset, [46:15] sized_value,
  // [78:47] original_value, [79] zero
  input  logic [79:0]  in_tdata,
  // [0] probe_ok
  input  logic         in_tuser,
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] slot, [14:3] record_offset, [27:15] next_offset,
  // [91:28] base_address, [155:92] total_length, [219:156] align_mask, [223:220] zero
  output logic [223:0] out_tdata,
  // [2:0] status, [5:3] bar_kind
  output logic [5:0]   out_tuser
);

  sbs_pkg::sbs_cfg_t cfg_r;
  sbs_pkg::sbs_op_t  f_op, q_op;
  logic              f_push, q_full, q_valid, q_pop, acc;

  logic [2:0]  o_slot, o_status, o_kind;
  logic [11:0] o_roff;
  logic [12:0] o_noff;
  logic [63:0] o_base, o_len, o_align;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sriov_present <= 1'b0;
      cfg_r.vf_count      <= '0;
      cfg_r.page_size     <= sbs_pkg::PAGE_SIZE_RST;
      cfg_r.mem64_ok      <= 1'b0;
      cfg_r.pmem64_ok     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sbs_pkg::CFG_SRIOV_PRESENT: cfg_r.sriov_present <= cfg_wdata[0];
        sbs_pkg::CFG_VF_COUNT:      cfg_r.vf_count      <= cfg_wdata[15:0];
        sbs_pkg::CFG_PAGE_SIZE:     cfg_r.page_size     <= cfg_wdata;
        sbs_pkg::CFG_MEM64_OK:      cfg_r.mem64_ok      <= cfg_wdata[0];
        sbs_pkg::CFG_PMEM64_OK:     cfg_r.pmem64_ok     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  sbs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .acc            (acc),
    .bar_index      (in_tdata[2:0]),
    .bar_offset     (in_tdata[14:3]),
    .probe_ok       (in_tuser),
    .sized_value    (in_tdata[46:15]),
    .original_value (in_tdata[78:47]),
    .push           (f_push),
    .op             (f_op)
  );

  sbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .wr_op    (f_op),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_op    (q_op)
  );

  sbs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_op          (q_op),
    .pop           (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .slot          (o_slot),
    .record_offset (o_roff),
    .next_offset   (o_noff),
    .status        (o_status),
    .bar_kind      (o_kind),
    .base_address  (o_base),
    .total_length  (o_len),
    .align_mask    (o_align)
  );

  assign out_tdata = {4'd0, o_align, o_len, o_base, o_noff, o_roff, o_slot};
  assign out_tuser = {o_kind, o_status};

endmodule
